### rtl/core/single_car_elevator_controller_core_assert.svh
// Assertion macros used by the elevator car state machine.
`ifndef SINGLE_CAR_ELEVATOR_CONTROLLER_CORE_ASSERT_SVH
`define SINGLE_CAR_ELEVATOR_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SCEC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("elevator controller check failed");

// Next-cycle implication, disabled while reset is high.
`define SCEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("elevator controller check failed");

`endif

### rtl/core/scec_pkg.sv
// Package with the car mode type, output codes and register indexes.
package scec_pkg;

  typedef enum logic [3:0] {
    MODE_STOPPED = 4'b0001,
    MODE_UP      = 4'b0010,
    MODE_DOWN    = 4'b0100,
    MODE_DOOR    = 4'b1000
  } mode_t;

  localparam logic [1:0] CAR_STOPPED = 2'd0;
  localparam logic [1:0] CAR_UP      = 2'd1;
  localparam logic [1:0] CAR_DOWN    = 2'd2;
  localparam logic [1:0] CAR_DOOR    = 2'd3;

  localparam int REG_INDEX_WIDTH = 2;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_TOP_FLOOR  = 2'd0;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_MOVE_TICKS = 2'd1;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_DOOR_TICKS = 2'd2;

  localparam int TOP_FLOOR_RESET  = 5;
  localparam int MOVE_TICKS_RESET = 10;
  localparam int DOOR_TICKS_RESET = 30;
  localparam int FLOOR_RESET      = 1;
  localparam int TARGET_NONE      = 0;

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] code;
    code = CAR_STOPPED;
    unique case (m)
      MODE_STOPPED: code = CAR_STOPPED;
      MODE_UP:      code = CAR_UP;
      MODE_DOWN:    code = CAR_DOWN;
      MODE_DOOR:    code = CAR_DOOR;
      default:      code = CAR_STOPPED;
    endcase
    return code;
  endfunction

endpackage

### rtl/core/scec_cfg_regs.sv
// Configuration registers for floor limit and travel and door timing.
module scec_cfg_regs
  import scec_pkg::*;
#(
  parameter int FLOOR_WIDTH = 4,
  parameter int TICK_WIDTH  = 8,
  parameter int DATA_WIDTH  = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [REG_INDEX_WIDTH-1:0] wr_index,
  input  logic [DATA_WIDTH-1:0]      wr_data,
  output logic [FLOOR_WIDTH-1:0]     top_floor,
  output logic [TICK_WIDTH-1:0]      move_ticks,
  output logic [TICK_WIDTH-1:0]      door_ticks
);

  always_ff @(posedge clk) begin
    if (rst) begin
      top_floor  <= FLOOR_WIDTH'(TOP_FLOOR_RESET);
      move_ticks <= TICK_WIDTH'(MOVE_TICKS_RESET);
      door_ticks <= TICK_WIDTH'(DOOR_TICKS_RESET);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TOP_FLOOR:  top_floor  <= wr_data[FLOOR_WIDTH-1:0];
        REG_MOVE_TICKS: move_ticks <= wr_data[TICK_WIDTH-1:0];
        REG_DOOR_TICKS: door_ticks <= wr_data[TICK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/scec_car_fsm.sv
// Car state machine: applies one tick or request per step.
module scec_car_fsm
  import scec_pkg::*;
#(
  parameter int FLOOR_WIDTH = 4,
  parameter int TICK_WIDTH  = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   operation,
  input  logic [FLOOR_WIDTH-1:0] requested_floor,
  input  logic [FLOOR_WIDTH-1:0] top_floor,
  input  logic [TICK_WIDTH-1:0]  move_ticks,
  input  logic [TICK_WIDTH-1:0]  door_ticks,
  output logic [FLOOR_WIDTH-1:0] floor_next,
  output mode_t                  mode_next,
  output logic [FLOOR_WIDTH-1:0] target_next,
  output logic                   taken
);

  `include "single_car_elevator_controller_core_assert.svh"

  localparam logic [FLOOR_WIDTH-1:0] NO_TARGET = FLOOR_WIDTH'(TARGET_NONE);

  mode_t                  mode_reg;
  logic [FLOOR_WIDTH-1:0] floor_reg;
  logic [FLOOR_WIDTH-1:0] target_reg;
  logic [TICK_WIDTH-1:0]  travel_count;
  logic [TICK_WIDTH-1:0]  open_count;
  logic [TICK_WIDTH-1:0]  travel_count_next;
  logic [TICK_WIDTH-1:0]  open_count_next;
  logic [TICK_WIDTH-1:0]  travel_inc;
  logic [TICK_WIDTH-1:0]  open_inc;
  logic [FLOOR_WIDTH-1:0] floor_step;

  assign travel_inc = travel_count + TICK_WIDTH'(1);
  assign open_inc   = open_count + TICK_WIDTH'(1);
  assign floor_step = (mode_reg == MODE_UP) ? floor_reg + FLOOR_WIDTH'(1)
                                            : floor_reg - FLOOR_WIDTH'(1);

  always_comb begin
    mode_next         = mode_reg;
    floor_next        = floor_reg;
    target_next       = target_reg;
    travel_count_next = travel_count;
    open_count_next   = open_count;
    taken             = 1'b0;
    if (operation) begin
      if (mode_reg == MODE_STOPPED && requested_floor != NO_TARGET &&
          requested_floor <= top_floor && requested_floor != floor_reg) begin
        target_next = requested_floor;
        taken       = 1'b1;
      end
    end else begin
      unique case (mode_reg)
        MODE_STOPPED: begin
          if (target_reg != NO_TARGET) begin
            mode_next = (target_reg > floor_reg) ? MODE_UP : MODE_DOWN;
          end
        end
        MODE_UP, MODE_DOWN: begin
          if (travel_inc >= move_ticks) begin
            floor_next        = floor_step;
            travel_count_next = '0;
            if (floor_step == target_reg) begin
              mode_next       = MODE_DOOR;
              open_count_next = '0;
            end
          end else begin
            travel_count_next = travel_inc;
          end
        end
        MODE_DOOR: begin
          if (open_inc >= door_ticks) begin
            target_next     = NO_TARGET;
            open_count_next = '0;
            mode_next       = MODE_STOPPED;
          end else begin
            open_count_next = open_inc;
          end
        end
        default: mode_next = MODE_STOPPED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_STOPPED;
      floor_reg    <= FLOOR_WIDTH'(FLOOR_RESET);
      target_reg   <= NO_TARGET;
      travel_count <= '0;
      open_count   <= '0;
    end else if (step) begin
      mode_reg     <= mode_next;
      floor_reg    <= floor_next;
      target_reg   <= target_next;
      travel_count <= travel_count_next;
      open_count   <= open_count_next;
    end
  end

  // A car that is not stopped always has a target to serve.
  `SCEC_ASSERT_NOW(a_target_when_busy, clk, rst, mode_reg != MODE_STOPPED, target_reg != NO_TARGET)
  // The car never sits at floor zero.
  `SCEC_ASSERT_NOW(a_floor_nonzero, clk, rst, 1'b1, floor_reg != '0)
  // An accepted request leaves the car stopped with that target set.
  `SCEC_ASSERT_NEXT(a_taken_sets_target, clk, rst, step && taken, mode_reg == MODE_STOPPED && target_reg == $past(requested_floor))

endmodule

### rtl/core/single_car_elevator_controller_core.sv
// Top level: configuration registers, input register, car state machine, result register.
// A request waits in the input register until the result register can take its result.
// Throughput: one request per cycle while the output is not stalled; while a result
// waits, the input register holds at most one more request and then stalls the input.
// Reset (rst, synchronous, active high) restores the configuration to its
// defaults, parks the car stopped at floor 1 with no target, and empties both registers.
module single_car_elevator_controller_core
  import scec_pkg::*;
#(
  parameter int FLOOR_WIDTH = 4,
  parameter int TICK_WIDTH  = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       operation,
  input  logic [FLOOR_WIDTH-1:0]     requested_floor,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [FLOOR_WIDTH-1:0]     floor_now,
  output logic [1:0]                 car_mode,
  output logic [FLOOR_WIDTH-1:0]     pending_target,
  output logic                       request_taken,
  input  logic                       wr_en,
  input  logic [REG_INDEX_WIDTH-1:0] wr_index,
  input  logic [((FLOOR_WIDTH > TICK_WIDTH) ? FLOOR_WIDTH : TICK_WIDTH)-1:0] wr_data
);

  localparam int DATA_WIDTH = (FLOOR_WIDTH > TICK_WIDTH) ? FLOOR_WIDTH : TICK_WIDTH;

  logic [FLOOR_WIDTH-1:0] top_floor;
  logic [TICK_WIDTH-1:0]  move_ticks;
  logic [TICK_WIDTH-1:0]  door_ticks;

  logic                   held_valid;
  logic                   held_operation;
  logic [FLOOR_WIDTH-1:0] held_floor;
  logic                   advance;
  logic                   step;

  logic [FLOOR_WIDTH-1:0] floor_next;
  mode_t                  mode_next;
  logic [FLOOR_WIDTH-1:0] target_next;
  logic                   taken;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = held_valid && !advance;
  assign step     = held_valid && advance;

  scec_cfg_regs #(
    .FLOOR_WIDTH(FLOOR_WIDTH),
    .TICK_WIDTH (TICK_WIDTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .top_floor (top_floor),
    .move_ticks(move_ticks),
    .door_ticks(door_ticks)
  );

  scec_car_fsm #(
    .FLOOR_WIDTH(FLOOR_WIDTH),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_fsm (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .operation      (held_operation),
    .requested_floor(held_floor),
    .top_floor      (top_floor),
    .move_ticks     (move_ticks),
    .door_ticks     (door_ticks),
    .floor_next     (floor_next),
    .mode_next      (mode_next),
    .target_next    (target_next),
    .taken          (taken)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_operation <= operation;
      held_floor     <= requested_floor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      floor_now      <= floor_next;
      car_mode       <= mode_code(mode_next);
      pending_target <= target_next;
      request_taken  <= taken;
    end
  end

endmodule

### sim/single_car_elevator_controller_core_tb.sv
// Self-checking testbench for the single-car elevator controller with a built-in car predictor.
module single_car_elevator_controller_core_tb
  import scec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [3:0] at_floor;
    logic [1:0] mode;
    logic [3:0] target;
    logic       taken;
  } car_result_t;

  typedef struct packed {
    logic        op;
    logic [3:0]  flr;
    logic        typed;
    car_result_t res;
  } stim_row_t;

  typedef struct packed {
    logic        typed;
    car_result_t res;
  } pend_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       operation = 1'b0;
  logic [3:0] requested_floor = 4'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] floor_now;
  logic [1:0] car_mode;
  logic [3:0] pending_target;
  logic       request_taken;
  logic       wr_en = 1'b0;
  logic [REG_INDEX_WIDTH-1:0] wr_index = REG_TOP_FLOOR;
  logic [7:0] wr_data = 8'd0;

  single_car_elevator_controller_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .requested_floor(requested_floor),
    .out_valid(out_valid), .out_stall(out_stall),
    .floor_now(floor_now), .car_mode(car_mode),
    .pending_target(pending_target), .request_taken(request_taken),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted car state and configuration.
  logic [1:0] p_mode = CAR_STOPPED;
  logic [3:0] p_floor = 4'(FLOOR_RESET);
  logic [3:0] p_target = 4'(TARGET_NONE);
  logic [7:0] p_travel = 8'd0;
  logic [7:0] p_open = 8'd0;
  logic [3:0] p_top = 4'(TOP_FLOOR_RESET);
  logic [7:0] p_move = 8'(MOVE_TICKS_RESET);
  logic [7:0] p_door = 8'(DOOR_TICKS_RESET);

  pend_t       pend_q[$];
  car_result_t car_expect_q[$];
  stim_row_t   dir_q[$];

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  errors = 0;
  int  accepted_cnt = 0;
  int  result_cnt = 0;
  int  setting_cnt = 0;
  int  quiet = 0;
  int  hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  function automatic car_result_t advance_car(input logic op, input logic [3:0] flr);
    car_result_t r;
    r.taken = 1'b0;
    if (op) begin
      if (p_mode == CAR_STOPPED && flr >= 4'd1 && flr <= p_top && flr != p_floor) begin
        p_target = flr;
        r.taken = 1'b1;
      end
    end else begin
      case (p_mode)
        CAR_STOPPED: begin
          if (p_target != 4'(TARGET_NONE))
            p_mode = (p_target > p_floor) ? CAR_UP : CAR_DOWN;
        end
        CAR_UP, CAR_DOWN: begin
          p_travel = p_travel + 8'd1;
          if (p_travel >= p_move) begin
            p_floor = (p_mode == CAR_UP) ? p_floor + 4'd1 : p_floor - 4'd1;
            p_travel = 8'd0;
            if (p_floor == p_target) begin
              p_mode = CAR_DOOR;
              p_open = 8'd0;
            end
          end
        end
        default: begin
          p_open = p_open + 8'd1;
          if (p_open >= p_door) begin
            p_target = 4'(TARGET_NONE);
            p_open = 8'd0;
            p_mode = CAR_STOPPED;
          end
        end
      endcase
    end
    r.at_floor = p_floor;
    r.mode = p_mode;
    r.target = p_target;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input logic op, input logic [3:0] flr, input logic typed,
                                       input logic [3:0] f, input logic [1:0] m,
                                       input logic [3:0] t, input logic k);
    stim_row_t s;
    s.op = op;
    s.flr = flr;
    s.typed = typed;
    s.res = '{at_floor: f, mode: m, target: t, taken: k};
    return s;
  endfunction

  always @(posedge clk) begin : request_monitor
    pend_t p;
    car_result_t got;
    if (!rst && in_valid && !in_stall) begin
      p = pend_q.pop_front();
      got = advance_car(operation, requested_floor);
      car_expect_q.push_back(p.typed ? p.res : got);
      accepted_cnt++;
    end
  end

  always @(posedge clk) begin : result_checker
    car_result_t e;
    if (!rst && out_valid && !out_stall) begin
      result_cnt++;
      if (car_expect_q.size() == 0) begin
        $error("Result arrived with no request outstanding.");
        errors++;
      end else begin
        e = car_expect_q.pop_front();
        if (floor_now !== e.at_floor) begin
          $error("floor_now: expected %0d, got %0d", e.at_floor, floor_now);
          errors++;
        end
        if (car_mode !== e.mode) begin
          $error("car_mode: expected %0d, got %0d", e.mode, car_mode);
          errors++;
        end
        if (pending_target !== e.target) begin
          $error("pending_target: expected %0d, got %0d", e.target, pending_target);
          errors++;
        end
        if (request_taken !== e.taken) begin
          $error("request_taken: expected %0d, got %0d", e.taken, request_taken);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(input logic op, input logic [3:0] flr, input logic typed,
                           input car_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pend_q.push_back('{typed: typed, res: res});
    in_valid <= 1'b1;
    operation <= op;
    requested_floor <= flr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pend_q.size() != 0 || car_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(input int top, input int move, input int door);
    wr_en <= 1'b1;
    wr_index <= REG_TOP_FLOOR;
    wr_data <= 8'(top);
    @(posedge clk);
    p_top = 4'(top);
    wr_index <= REG_MOVE_TICKS;
    wr_data <= 8'(move);
    @(posedge clk);
    p_move = 8'(move);
    wr_index <= REG_DOOR_TICKS;
    wr_data <= 8'(door);
    @(posedge clk);
    p_door = 8'(door);
    wr_en <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    int tries;
    logic op;
    logic [3:0] flr;
    r = $urandom_range(99);
    op = 1'b0;
    flr = 4'($urandom_range(15));
    if (r < 8) begin
      op = 1'($urandom_range(1));
    end else if (p_mode == CAR_STOPPED &&
                 r < ((p_target == 4'(TARGET_NONE)) ? 75 : 30)) begin
      op = 1'b1;
      if (p_top >= 4'd2) begin
        tries = 0;
        do begin
          flr = 4'($urandom_range(p_top, 1));
          tries++;
        end while (flr == p_floor && tries < 20);
      end
    end else if (r < 14) begin
      op = 1'b1;
    end
    send_item(op, flr, 1'b0, '0);
  endtask

  task automatic run_phase(input int top, input int move, input int door,
                           input int idle_pct, input int stall_p, input int n);
    drain();
    write_settings(top, move, door);
    setting_cnt++;
    send_idle_pct = idle_pct;
    stall_pct = stall_p;
    repeat (n) random_item();
  endtask

  initial begin : main
    stim_row_t s;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: top floor 5, ten ticks per floor, thirty door ticks.
    dir_q.push_back(mk_row(1'b0, 4'd0,  1'b1, 4'd1, CAR_STOPPED, 4'd0, 1'b0));
    dir_q.push_back(mk_row(1'b1, 4'd0,  1'b1, 4'd1, CAR_STOPPED, 4'd0, 1'b0));
    dir_q.push_back(mk_row(1'b1, 4'd15, 1'b1, 4'd1, CAR_STOPPED, 4'd0, 1'b0));
    dir_q.push_back(mk_row(1'b1, 4'd1,  1'b1, 4'd1, CAR_STOPPED, 4'd0, 1'b0));
    dir_q.push_back(mk_row(1'b1, 4'd6,  1'b1, 4'd1, CAR_STOPPED, 4'd0, 1'b0));
    dir_q.push_back(mk_row(1'b1, 4'd5,  1'b1, 4'd1, CAR_STOPPED, 4'd5, 1'b1));
    dir_q.push_back(mk_row(1'b1, 4'd2,  1'b1, 4'd1, CAR_STOPPED, 4'd2, 1'b1));
    dir_q.push_back(mk_row(1'b0, 4'd15, 1'b1, 4'd1, CAR_UP,      4'd2, 1'b0));
    dir_q.push_back(mk_row(1'b1, 4'd4,  1'b1, 4'd1, CAR_UP,      4'd2, 1'b0));
    for (int i = 0; i < 10; i++)
      dir_q.push_back(mk_row(1'b0, (i % 2) ? 4'd10 : 4'd5, 1'b0, 4'd0, CAR_STOPPED, 4'd0, 1'b0));
    dir_q.push_back(mk_row(1'b1, 4'd3,  1'b1, 4'd2, CAR_DOOR,    4'd2, 1'b0));
    dir_q.push_back(mk_row(1'b0, 4'd0,  1'b0, 4'd0, CAR_STOPPED, 4'd0, 1'b0));
    foreach (dir_q[i]) begin
      s = dir_q[i];
      send_item(s.op, s.flr, s.typed, s.res);
    end

    // The long output hold-off starts while requests keep coming.
    drain();
    write_settings(15, 1, 1);
    setting_cnt++;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req <= 1'b1;
    repeat (60) random_item();

    run_phase(2, 2, 3, 81, 0, 40);
    run_phase(15, 3, 2, 0, 81, 40);
    run_phase(9, 1, 4, 34, 34, 40);
    run_phase(1, 0, 0, 0, 0, 30);
    run_phase(0, 5, 1, 81, 0, 20);
    run_phase(2, 255, 255, 0, 0, 300);
    run_phase(15, 1, 1, 34, 34, 40);
    run_phase(12, 7, 9, 0, 0, 40);
    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d requests and %0d results over %0d settings,", accepted_cnt,
             result_cnt, setting_cnt);
    $display("including zero and maximum tick limits and a long output hold-off.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/scec_pkg.sv
rtl/core/scec_cfg_regs.sv
rtl/core/scec_car_fsm.sv
rtl/core/single_car_elevator_controller_core.sv
sim/single_car_elevator_controller_core_tb.sv
